// File: hw/rtl/stable_argsort_defines.svh
// Assertion macros for the stable argsort block.
`ifndef STABLE_ARGSORT_DEFINES_SVH
`define STABLE_ARGSORT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define STSORT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define STSORT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stsort_pkg.sv
// Shared types and constants of the stable argsort block.
package stsort_pkg;

  localparam int MAX_N_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int OIDX_W       = 6;
  localparam int OUT_TDATA_W  = 40;

  typedef struct packed {
    logic ins;
    logic drain;
  } stsort_ctl_t;

  typedef struct packed {
    logic valid;
    logic gt;
  } stsort_link_t;

endpackage

// File: hw/rtl/stable_argsort.sv
// Top level of the stable argsort block: insertion chain of compare cells.
// Input: one beat per cycle while loading; the chain inserts each key as it is accepted.
// Output: first result is valid the cycle after the last input beat, then one per cycle while m_tready is high.
// No input is taken while draining.
// Reset (rst, synchronous) empties the chain and clears fill count and drop flag; no clearing pass.
`include "stable_argsort_defines.svh"

module stable_argsort #(
  parameter int MAX_N    = stsort_pkg::MAX_N_DEF,
  parameter int KEY_BITS = stsort_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [stsort_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
  input  logic                                s_tlast,   // last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [stsort_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [5:0] orig_index, [37:6] sorted_value
  output logic                                m_tlast,   // end_of_list
  output logic                                m_tuser    // overflow
);

  localparam int IDX_W = $clog2(MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);

  stsort_pkg::stsort_ctl_t  ctl;
  stsort_pkg::stsort_link_t lnk   [MAX_N];
  logic [KEY_BITS-1:0]      key_q [MAX_N];
  logic [IDX_W-1:0]         idx_q [MAX_N];

  logic [CNT_W-1:0]         fill;
  logic                     dropped;
  logic                     draining;
  logic                     in_acc;
  logic                     out_acc;
  logic                     room;
  logic [KEY_BITS-1:0]      new_key;
  logic [KEY_BITS+31:0]     in_wide;
  logic [KEY_BITS+31:0]     out_wide;
  logic [IDX_W+5:0]         idx_wide;

  assign in_wide = {{KEY_BITS{s_tdata[31]}}, s_tdata};
  assign new_key = in_wide[KEY_BITS-1:0];

  assign s_tready  = !draining;
  assign in_acc    = s_tvalid && s_tready;
  assign m_tvalid  = draining;
  assign out_acc   = m_tvalid && m_tready;
  assign room      = fill < CNT_W'(MAX_N);
  assign ctl.ins   = in_acc && room;
  assign ctl.drain = out_acc;

  for (genvar i = 0; i < MAX_N; i++) begin : g_cell
    stsort_pkg::stsort_link_t pl;
    stsort_pkg::stsort_link_t nl;
    logic [KEY_BITS-1:0]      pk;
    logic [KEY_BITS-1:0]      nk;
    logic [IDX_W-1:0]         pi;
    logic [IDX_W-1:0]         ni;

    if (i == 0) begin : g_head
      assign pl = '{valid: 1'b1, gt: 1'b0};
      assign pk = '0;
      assign pi = '0;
    end else begin : g_prev
      assign pl = lnk[i-1];
      assign pk = key_q[i-1];
      assign pi = idx_q[i-1];
    end

    if (i == MAX_N - 1) begin : g_tail
      assign nl = '{valid: 1'b0, gt: 1'b0};
      assign nk = '0;
      assign ni = '0;
    end else begin : g_next
      assign nl = lnk[i+1];
      assign nk = key_q[i+1];
      assign ni = idx_q[i+1];
    end

    stsort_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_key   (new_key),
      .new_idx   (fill[IDX_W-1:0]),
      .prev_link (pl),
      .prev_key  (pk),
      .prev_idx  (pi),
      .next_link (nl),
      .next_key  (nk),
      .next_idx  (ni),
      .link      (lnk[i]),
      .key       (key_q[i]),
      .idx       (idx_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      dropped  <= 1'b0;
      draining <= 1'b0;
    end else if (draining) begin
      if (out_acc && m_tlast) begin
        draining <= 1'b0;
        fill     <= '0;
        dropped  <= 1'b0;
      end
    end else if (in_acc) begin
      if (room) begin
        fill <= fill + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
      if (s_tlast) begin
        draining <= 1'b1;
      end
    end
  end

  assign out_wide = {{32{key_q[0][KEY_BITS-1]}}, key_q[0]};
  assign idx_wide = {6'b000000, idx_q[0]};
  assign m_tdata  = {2'b00, out_wide[31:0], idx_wide[5:0]};
  assign m_tlast  = !lnk[1].valid;
  assign m_tuser  = dropped;

  `STSORT_ASSERT_NOW(a_head_valid, m_tvalid, lnk[0].valid, "draining with empty head cell")
  `STSORT_ASSERT_NOW(a_empty_chain, !draining && fill == '0, !lnk[0].valid,
                     "chain holds data with zero fill count")
  `STSORT_ASSERT_NEXT(a_last_in, in_acc && s_tlast, m_tvalid,
                      "no results after last input beat")
  `STSORT_ASSERT_NEXT(a_last_out, out_acc && m_tlast, !m_tvalid && fill == '0 && !lnk[0].valid,
                      "list not cleared after final result")

endmodule

// File: hw/rtl/stsort_cell.sv
// One insertion cell: holds a key and its index, shifts up on insert, down on drain.
module stsort_cell #(
  parameter int KEY_BITS = stsort_pkg::KEY_BITS_DEF,
  parameter int IDX_W    = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  stsort_pkg::stsort_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]        new_key,
  input  logic [IDX_W-1:0]           new_idx,
  input  stsort_pkg::stsort_link_t   prev_link,
  input  logic [KEY_BITS-1:0]        prev_key,
  input  logic [IDX_W-1:0]           prev_idx,
  input  stsort_pkg::stsort_link_t   next_link,
  input  logic [KEY_BITS-1:0]        next_key,
  input  logic [IDX_W-1:0]           next_idx,
  output stsort_pkg::stsort_link_t   link,
  output logic [KEY_BITS-1:0]        key,
  output logic [IDX_W-1:0]           idx
);

  logic valid;
  logic le;

  assign le         = $signed(key) <= $signed(new_key);
  assign link.valid = valid;
  assign link.gt    = valid && !le;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= next_link.valid;
      key   <= next_key;
      idx   <= next_idx;
    end else if (ctl.ins) begin
      if (prev_link.gt) begin
        valid <= 1'b1;
        key   <= prev_key;
        idx   <= prev_idx;
      end else if (link.gt || (!valid && prev_link.valid)) begin
        valid <= 1'b1;
        key   <= new_key;
        idx   <= new_idx;
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for stable_argsort: directed and random lists checked against a sorting predictor.
module testbench;

  localparam int CAPACITY    = stsort_pkg::MAX_N_DEF;
  localparam int VALUE_W     = stsort_pkg::VALUE_W;
  localparam int OIDX_W      = stsort_pkg::OIDX_W;
  localparam int OUT_TDATA_W = stsort_pkg::OUT_TDATA_W;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {KEY_FULL, KEY_TIES, KEY_EXTREME} key_mix_t;

  typedef struct packed {
    logic [OIDX_W-1:0]  idx;
    logic [VALUE_W-1:0] key;
    logic               eol;
    logic               ovf;
  } sorted_entry_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [VALUE_W-1:0]     s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  stable_argsort dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  // predicted chain contents, kept sorted
  logic signed [VALUE_W-1:0] chain_key[$];
  logic [OIDX_W-1:0]         chain_idx[$];
  bit                        chain_dropped;
  sorted_entry_t             pending_sorted[$];
  sorted_entry_t             head;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int lists_sent;
  int keys_sent;
  int results_seen;
  int overflow_lists;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic chain_insert(input logic signed [VALUE_W-1:0] key, input logic fin);
    int pos;
    int fill;
    sorted_entry_t ent;
    fill = chain_key.size();
    if (fill < CAPACITY) begin
      pos = fill;
      while (pos > 0 && chain_key[pos-1] > key) pos--;
      chain_key.insert(pos, key);
      chain_idx.insert(pos, OIDX_W'(fill));
    end else begin
      chain_dropped = 1'b1;
    end
    if (fin) begin
      foreach (chain_key[k]) begin
        ent.idx = chain_idx[k];
        ent.key = chain_key[k];
        ent.eol = (k == chain_key.size() - 1);
        ent.ovf = chain_dropped;
        pending_sorted.push_back(ent);
      end
      if (chain_dropped) overflow_lists++;
      chain_key.delete();
      chain_idx.delete();
      chain_dropped = 1'b0;
    end
  endtask

  // beat monitor, result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        keys_sent++;
        chain_insert(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_sorted.size() == 0) begin
          errors++;
          $display("%0t: unexpected result idx=%0d value=%0d last=%b ovf=%b", $time,
                   m_tdata[5:0], $signed(m_tdata[37:6]), m_tlast, m_tuser);
        end else begin
          head = pending_sorted.pop_front();
          if (m_tdata[5:0] !== head.idx) begin
            errors++;
            $display("%0t: orig_index expected %0d actual %0d", $time, head.idx, m_tdata[5:0]);
          end
          if (m_tdata[37:6] !== head.key) begin
            errors++;
            $display("%0t: sorted_value expected %0d actual %0d", $time,
                     $signed(head.key), $signed(m_tdata[37:6]));
          end
          if (m_tlast !== head.eol) begin
            errors++;
            $display("%0t: end_of_list expected %b actual %b", $time, head.eol, m_tlast);
          end
          if (m_tuser !== head.ovf) begin
            errors++;
            $display("%0t: overflow expected %b actual %b", $time, head.ovf, m_tuser);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results pending", $time, idle_cycles,
                 pending_sorted.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_key(input logic [VALUE_W-1:0] v, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [VALUE_W-1:0] rand_key(input key_mix_t mix);
    case (mix)
      KEY_TIES: rand_key = VALUE_W'($signed($urandom_range(8)) - 4);
      KEY_EXTREME: begin
        case ($urandom_range(4))
          0: rand_key = 32'h8000_0000;
          1: rand_key = 32'h7fff_ffff;
          2: rand_key = 32'h0000_0000;
          3: rand_key = 32'hffff_ffff;
          default: rand_key = 32'h0000_0001;
        endcase
      end
      default: rand_key = $urandom;
    endcase
  endfunction

  task automatic send_list(input int len, input key_mix_t mix);
    for (int i = 0; i < len; i++) send_key(rand_key(mix), i == len - 1);
    lists_sent++;
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] mixed[7];
    mixed = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000,
              32'h7fff_ffff};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // single-element lists at both extremes
    send_key(32'h8000_0000, 1'b1);
    send_key(32'h7fff_ffff, 1'b1);
    // all keys equal: arrival order must hold
    for (int i = 0; i < 4; i++) send_key(32'd5, i == 3);
    foreach (mixed[i]) send_key(mixed[i], i == 6);
    // strictly descending, then ascending
    for (int i = 0; i < 6; i++) send_key(VALUE_W'(4 - i), i == 5);
    for (int i = 0; i < 3; i++) send_key(VALUE_W'(i - 1), i == 2);
    lists_sent += 6;
  endtask

  task automatic test_capacity();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    // exactly full, then over capacity with the last three beats dropped
    send_list(CAPACITY, KEY_TIES);
    send_list(CAPACITY + 3, KEY_FULL);
  endtask

  task automatic test_random_lists(input int items, input int idle_pct, input int stall_pct);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(19) == 0) len = $urandom_range(CAPACITY + 6, CAPACITY - 8);
      else len = $urandom_range(10, 1);
      send_list(len, key_mix_t'($urandom_range(2)));
      sent += len;
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    lists_sent     = 0;
    keys_sent      = 0;
    results_seen   = 0;
    overflow_lists = 0;
    chain_dropped  = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_capacity();
    test_random_lists(25, 0, 0);
    test_random_lists(25, 58, 0);
    test_random_lists(25, 0, 58);
    test_random_lists(25, 20, 20);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sorted %0d lists (%0d over capacity) from %0d key beats", lists_sent,
             overflow_lists, keys_sent);
    $display("Checked %0d result beats under four idle/stall mixes, %0d errors", results_seen,
             errors);
    if (errors == 0 && pending_sorted.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
